// ===== hw/rtl/lbc_pkg.sv =====
package lbc_pkg;

  localparam int COORD_WIDTH_DEF   = 16;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int NUM_EDGES         = 4;
  localparam int CFG_ADDR_WIDTH    = 4;
  localparam int CFG_DATA_WIDTH    = 32;

  localparam int WIN_LEFT_RST   = 0;
  localparam int WIN_BOTTOM_RST = 0;
  localparam int WIN_RIGHT_RST  = 639;
  localparam int WIN_TOP_RST    = 479;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_BOTTOM = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_TOP    = 2'd3
  } lbc_reg_t;

  // Per-edge flags that travel with the quotient through the divider.
  typedef struct packed {
    logic p_zero;
    logic p_neg;
    logic q_neg;
    logic r_neg;
  } lbc_edge_t;

endpackage

// ===== hw/rtl/lbc_if.sv =====
interface lbc_in_if #(parameter int CW = 16);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lbc_out_if #(parameter int CW = 16);
  logic                 valid;
  logic                 ready;
  logic                 accepted;
  logic signed [CW-1:0] clip_start_x;
  logic signed [CW-1:0] clip_start_y;
  logic signed [CW-1:0] clip_end_x;
  logic signed [CW-1:0] clip_end_y;

  modport source (output valid, accepted, clip_start_x, clip_start_y, clip_end_x, clip_end_y,
                  input ready);
  modport sink   (input valid, accepted, clip_start_x, clip_start_y, clip_end_x, clip_end_y,
                  output ready);
endinterface

// ===== hw/rtl/line_segment_rect_clipper.sv =====
// Channel   Direction  Protocol        Payload
// in_ch     input      valid/ready     start_x, start_y, end_x, end_y
// out_ch    output     valid/ready     accepted, clip_start_x/y, clip_end_x/y
// APB       input      psel/penable    window_left, window_bottom, window_right, window_top
//
// One segment per cycle while the output is not stalled; the four restoring
// dividers produce one quotient bit per stage.
// Reset clears all valid bits and loads the default window.
// The whole pipeline holds while the output register is full and not taken.
module line_segment_rect_clipper import lbc_pkg::*; #(
  parameter int COORD_WIDTH   = COORD_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  lbc_in_if.sink                    in_ch,
  lbc_out_if.source                 out_ch,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_DATA_WIDTH-1:0] pwdata,
  output logic [CFG_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  localparam int CW  = COORD_WIDTH;
  localparam int FB  = FRACTION_BITS;
  localparam int MW  = CW + 1;
  localparam int TW  = FB + 3;
  localparam int NS  = FB + 5;
  localparam int C_ST = FB + 2;
  localparam int M_ST = FB + 3;
  localparam logic signed [TW-1:0] T_ONE = TW'(1) << FB;

  logic signed [CW-1:0] win_left, win_bottom, win_right, win_top;
  logic                 ce;
  logic [NS-1:0]        vld_r;

  logic signed [CW-1:0] x1_r [M_ST+1];
  logic signed [CW-1:0] y1_r [M_ST+1];
  logic signed [MW-1:0] dx_r [M_ST+1];
  logic signed [MW-1:0] dy_r [M_ST+1];

  logic signed [MW-1:0] ep_r [NUM_EDGES];
  logic signed [MW-1:0] eq_r [NUM_EDGES];
  lbc_edge_t            ef   [NUM_EDGES];
  logic [FB+1:0]        em   [NUM_EDGES];

  logic signed [MW-1:0] dx_c, dy_c;
  logic signed [TW-1:0] tin_c, tout_c, r_c;
  logic                 rej_c;
  logic [FB:0]          tin_r, tout_r;
  logic                 rej_r, acc_r;

  lbc_cfg_regs #(.CW(CW)) u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .win_left, .win_bottom, .win_right, .win_top
  );

  assign ce          = !vld_r[NS-1] || out_ch.ready;
  assign in_ch.ready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ce) begin
      vld_r <= {vld_r[NS-2:0], in_ch.valid};
    end
  end

  assign dx_c = MW'(in_ch.end_x) - MW'(in_ch.start_x);
  assign dy_c = MW'(in_ch.end_y) - MW'(in_ch.start_y);

  // Input stage: edge terms p and q for left, right, bottom and top.
  always_ff @(posedge clk) begin
    if (ce) begin
      x1_r[0] <= in_ch.start_x;
      y1_r[0] <= in_ch.start_y;
      dx_r[0] <= dx_c;
      dy_r[0] <= dy_c;
      ep_r[0] <= -dx_c;
      eq_r[0] <= MW'(in_ch.start_x) - MW'(win_left);
      ep_r[1] <= dx_c;
      eq_r[1] <= MW'(win_right) - MW'(in_ch.start_x);
      ep_r[2] <= -dy_c;
      eq_r[2] <= MW'(in_ch.start_y) - MW'(win_bottom);
      ep_r[3] <= dy_c;
      eq_r[3] <= MW'(win_top) - MW'(in_ch.start_y);
      for (int i = 1; i <= M_ST; i++) begin
        x1_r[i] <= x1_r[i-1];
        y1_r[i] <= y1_r[i-1];
        dx_r[i] <= dx_r[i-1];
        dy_r[i] <= dy_r[i-1];
      end
    end
  end

  for (genvar g = 0; g < NUM_EDGES; g++) begin : g_edge
    lbc_edge_div #(.CW(CW), .FB(FB)) u_div (
      .clk, .ce, .p(ep_r[g]), .q(eq_r[g]), .flags(ef[g]), .mag(em[g])
    );
  end

  always_comb begin
    tin_c  = '0;
    tout_c = T_ONE;
    rej_c  = 1'b0;
    r_c    = '0;
    for (int i = 0; i < NUM_EDGES; i++) begin
      r_c = ef[i].r_neg ? -$signed({1'b0, em[i]}) : $signed({1'b0, em[i]});
      if (ef[i].p_zero) begin
        if (ef[i].q_neg) begin
          rej_c = 1'b1;
        end
      end else if (ef[i].p_neg) begin
        if (r_c > tin_c) begin
          tin_c = r_c;
        end
      end else begin
        if (r_c < tout_c) begin
          tout_c = r_c;
        end
      end
    end
    if (tin_c > tout_c) begin
      rej_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      tin_r  <= tin_c[FB:0];
      tout_r <= tout_c[FB:0];
      rej_r  <= rej_c;
      acc_r  <= !rej_r;
    end
  end

  lbc_endpoint #(.CW(CW), .FB(FB)) u_sx (
    .clk, .ce, .delta(dx_r[C_ST]), .t(tin_r), .base(x1_r[M_ST]), .keep(acc_r),
    .coord(out_ch.clip_start_x)
  );
  lbc_endpoint #(.CW(CW), .FB(FB)) u_sy (
    .clk, .ce, .delta(dy_r[C_ST]), .t(tin_r), .base(y1_r[M_ST]), .keep(acc_r),
    .coord(out_ch.clip_start_y)
  );
  lbc_endpoint #(.CW(CW), .FB(FB)) u_ex (
    .clk, .ce, .delta(dx_r[C_ST]), .t(tout_r), .base(x1_r[M_ST]), .keep(acc_r),
    .coord(out_ch.clip_end_x)
  );
  lbc_endpoint #(.CW(CW), .FB(FB)) u_ey (
    .clk, .ce, .delta(dy_r[C_ST]), .t(tout_r), .base(y1_r[M_ST]), .keep(acc_r),
    .coord(out_ch.clip_end_y)
  );

  logic out_acc_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      out_acc_r <= acc_r;
    end
  end

  assign out_ch.valid    = vld_r[NS-1];
  assign out_ch.accepted = out_acc_r;

endmodule

// ===== hw/rtl/lbc_cfg_regs.sv =====
module lbc_cfg_regs import lbc_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_DATA_WIDTH-1:0] pwdata,
  output logic [CFG_DATA_WIDTH-1:0] prdata,
  output logic                      pready,
  output logic signed [CW-1:0]      win_left,
  output logic signed [CW-1:0]      win_bottom,
  output logic signed [CW-1:0]      win_right,
  output logic signed [CW-1:0]      win_top
);

  logic signed [CW-1:0] left_r, bottom_r, right_r, top_r;
  logic signed [CW-1:0] rd_val;
  lbc_reg_t             reg_sel;
  logic                 wr_en;

  assign reg_sel = lbc_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= CW'(WIN_LEFT_RST);
      bottom_r <= CW'(WIN_BOTTOM_RST);
      right_r  <= CW'(WIN_RIGHT_RST);
      top_r    <= CW'(WIN_TOP_RST);
    end else if (wr_en) begin
      case (reg_sel)
        REG_LEFT:   left_r   <= pwdata[CW-1:0];
        REG_BOTTOM: bottom_r <= pwdata[CW-1:0];
        REG_RIGHT:  right_r  <= pwdata[CW-1:0];
        REG_TOP:    top_r    <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_LEFT:   rd_val = left_r;
      REG_BOTTOM: rd_val = bottom_r;
      REG_RIGHT:  rd_val = right_r;
      REG_TOP:    rd_val = top_r;
      default:    rd_val = left_r;
    endcase
    prdata = CFG_DATA_WIDTH'(rd_val);
  end

  assign win_left   = left_r;
  assign win_bottom = bottom_r;
  assign win_right  = right_r;
  assign win_top    = top_r;

endmodule

// ===== hw/rtl/lbc_edge_div.sv =====
module lbc_edge_div import lbc_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int FB = FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               ce,
  input  logic signed [CW:0] p,
  input  logic signed [CW:0] q,
  output lbc_edge_t          flags,
  output logic [FB+1:0]      mag
);

  localparam int MW = CW + 1;
  localparam logic [FB+1:0] T_ONE = (FB+2)'(1) << FB;

  logic [MW-1:0] p_abs, q_abs, q_dif;
  logic          ge1, ge2;
  lbc_edge_t     flg_in;

  logic [MW-1:0] pa_r  [FB+1];
  logic [MW-1:0] rem_r [FB+1];
  logic [FB-1:0] quo_r [FB+1];
  logic          ge1_r [FB+1];
  logic          ge2_r [FB+1];
  lbc_edge_t     flg_r [FB+1];

  logic [MW-1:0] rem_nxt [FB+1];
  logic          bit_nxt [FB+1];
  logic [MW:0]   two;
  logic [MW:0]   dif;

  // The integer part of |q|/|p| only matters as zero, one or more; the
  // remainder then goes through one restoring step per fraction bit.
  always_comb begin
    p_abs = p[CW] ? MW'(-p) : MW'(p);
    q_abs = q[CW] ? MW'(-q) : MW'(q);
    q_dif = q_abs - p_abs;
    ge1   = q_abs >= p_abs;
    ge2   = ge1 && (q_dif >= p_abs);
    flg_in.p_zero = (p == '0);
    flg_in.p_neg  = p[CW];
    flg_in.q_neg  = q[CW];
    flg_in.r_neg  = p[CW] ^ q[CW];
  end

  always_comb begin
    two = '0;
    dif = '0;
    rem_nxt[0] = ge1 ? q_dif : q_abs;
    bit_nxt[0] = 1'b0;
    for (int k = 1; k <= FB; k++) begin
      two = {rem_r[k-1], 1'b0};
      dif = two - {1'b0, pa_r[k-1]};
      bit_nxt[k] = (two >= {1'b0, pa_r[k-1]});
      rem_nxt[k] = bit_nxt[k] ? dif[MW-1:0] : two[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      pa_r[0]  <= p_abs;
      rem_r[0] <= rem_nxt[0];
      quo_r[0] <= '0;
      ge1_r[0] <= ge1;
      ge2_r[0] <= ge2;
      flg_r[0] <= flg_in;
      for (int k = 1; k <= FB; k++) begin
        pa_r[k]  <= pa_r[k-1];
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= {quo_r[k-1][FB-2:0], bit_nxt[k]};
        ge1_r[k] <= ge1_r[k-1];
        ge2_r[k] <= ge2_r[k-1];
        flg_r[k] <= flg_r[k-1];
      end
    end
  end

  // Anything above one is held at one plus one lsb, which orders the same.
  always_comb begin
    if (ge2_r[FB]) begin
      mag = T_ONE + (FB+2)'(1);
    end else if (ge1_r[FB]) begin
      mag = T_ONE + (FB+2)'(quo_r[FB] != '0);
    end else begin
      mag = {2'b00, quo_r[FB]};
    end
    flags = flg_r[FB];
  end

endmodule

// ===== hw/rtl/lbc_endpoint.sv =====
module lbc_endpoint import lbc_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF,
  parameter int FB = FRACTION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 ce,
  input  logic signed [CW:0]   delta,
  input  logic [FB:0]          t,
  input  logic signed [CW-1:0] base,
  input  logic                 keep,
  output logic signed [CW-1:0] coord
);

  localparam int MW = CW + 1;
  localparam int PW = MW + FB + 2;
  localparam int RW = PW - FB + 1;
  localparam logic [PW-1:0] T_HALF = PW'(1) << (FB - 1);

  logic signed [PW-1:0] prod_r;
  logic [PW-1:0]        pmag;
  logic [PW-1:0]        psum;
  logic signed [RW-1:0] rnd;
  logic signed [RW-1:0] sum;
  logic signed [CW-1:0] coord_r;

  always_ff @(posedge clk) begin
    if (ce) begin
      prod_r <= delta * $signed({1'b0, t});
    end
  end

  // Rounding is half away from zero on the magnitude.
  always_comb begin
    pmag = prod_r[PW-1] ? PW'(-prod_r) : PW'(prod_r);
    psum = pmag + T_HALF;
    rnd  = $signed({1'b0, psum[PW-1:FB]});
    if (prod_r[PW-1]) begin
      rnd = -rnd;
    end
    sum = RW'(base) + rnd;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      coord_r <= keep ? sum[CW-1:0] : '0;
    end
  end

  assign coord = coord_r;

endmodule

// ===== tb/sv/line_segment_rect_clipper_checker.sv =====
`timescale 1ns / 100ps

module line_segment_rect_clipper_checker import lbc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  lbc_in_if.sink        seg_mon,
  lbc_out_if.sink       clip_mon,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [CFG_DATA_WIDTH-1:0] pwdata,
  output int            mismatch_count,
  output int            pending_count,
  output int            accept_count,
  output int            reject_count
);

  localparam longint T_ONE  = 64'sd1 << FRACTION_BITS_DEF;
  localparam longint T_HALF = 64'sd1 << (FRACTION_BITS_DEF - 1);

  typedef struct packed {
    logic               accepted;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
  } clip_t;

  clip_t  expected_clips[$];
  longint win_left, win_bottom, win_right, win_top;

  function automatic void clip_edge(input longint p, input longint q, inout longint t_in,
                                    inout longint t_out, inout bit rej);
    longint r;
    if (p == 0) begin
      if (q < 0) rej = 1;
    end else begin
      r = (q * T_ONE) / p;
      if (p < 0) begin
        if (r > t_in) t_in = r;
      end else if (r < t_out) begin
        t_out = r;
      end
    end
  endfunction

  function automatic longint scale_round(input longint d, input longint t);
    longint v;
    longint mag;
    v = d * t;
    mag = (v < 0) ? -v : v;
    mag = (mag + T_HALF) / T_ONE;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic clip_t clip_segment(input longint x1, input longint y1,
                                         input longint x2, input longint y2);
    longint dx, dy, t_in, t_out;
    bit     rej;
    clip_t  c;
    dx = x2 - x1;
    dy = y2 - y1;
    t_in = 0;
    t_out = T_ONE;
    rej = 0;
    clip_edge(-dx, x1 - win_left, t_in, t_out, rej);
    clip_edge(dx, win_right - x1, t_in, t_out, rej);
    clip_edge(-dy, y1 - win_bottom, t_in, t_out, rej);
    clip_edge(dy, win_top - y1, t_in, t_out, rej);
    c = '0;
    if (!rej && t_in <= t_out) begin
      c.accepted = 1'b1;
      c.sx = 16'(x1 + scale_round(dx, t_in));
      c.sy = 16'(y1 + scale_round(dy, t_in));
      c.ex = 16'(x1 + scale_round(dx, t_out));
      c.ey = 16'(y1 + scale_round(dy, t_out));
    end
    return c;
  endfunction

  assign pending_count = expected_clips.size();

  always @(posedge clk) begin
    clip_t want, got;
    if (!rst_n) begin
      win_left = WIN_LEFT_RST;
      win_bottom = WIN_BOTTOM_RST;
      win_right = WIN_RIGHT_RST;
      win_top = WIN_TOP_RST;
      mismatch_count = 0;
      accept_count = 0;
      reject_count = 0;
      expected_clips.delete();
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          REG_LEFT:   win_left   = longint'($signed(pwdata[15:0]));
          REG_BOTTOM: win_bottom = longint'($signed(pwdata[15:0]));
          REG_RIGHT:  win_right  = longint'($signed(pwdata[15:0]));
          REG_TOP:    win_top    = longint'($signed(pwdata[15:0]));
          default: ;
        endcase
      end
      if (clip_mon.valid && clip_mon.ready) begin
        got = {clip_mon.accepted, clip_mon.clip_start_x, clip_mon.clip_start_y,
               clip_mon.clip_end_x, clip_mon.clip_end_y};
        if (expected_clips.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result transfer %p", got);
        end else begin
          want = expected_clips.pop_front();
          if (got.accepted) accept_count++;
          else reject_count++;
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected %p, actual %p", want, got);
          end
        end
      end
      // The window is never written while segments are in flight.
      if (seg_mon.valid && seg_mon.ready)
        expected_clips.push_back(clip_segment(seg_mon.start_x, seg_mon.start_y,
                                              seg_mon.end_x, seg_mon.end_y));
    end
  end

endmodule

// ===== tb/sv/line_segment_rect_clipper_tb.sv =====
`timescale 1ns / 100ps

module line_segment_rect_clipper_tb import lbc_pkg::*;;

  localparam int LATENCY = FRACTION_BITS_DEF + 5;
  localparam int MAX_CYCLES = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_WIDTH-1:0] paddr = '0;
  logic [CFG_DATA_WIDTH-1:0] pwdata = '0;
  logic [CFG_DATA_WIDTH-1:0] prdata;
  logic pready;
  int   mismatch_count, pending_count, accept_count, reject_count;
  int   cycle_count = 0;
  int   segment_count = 0;
  bit   sink_idle_off = 1'b0;

  lbc_in_if  seg_ch ();
  lbc_out_if clip_ch ();

  line_segment_rect_clipper i_dut (
    .clk, .rst_n, .in_ch(seg_ch), .out_ch(clip_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  line_segment_rect_clipper_checker i_checker (
    .clk, .rst_n, .seg_mon(seg_ch), .clip_mon(clip_ch),
    .psel, .penable, .pwrite, .paddr, .pwdata,
    .mismatch_count, .pending_count, .accept_count, .reject_count
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    seg_ch.valid = 1'b0;
    seg_ch.start_x = '0;
    seg_ch.start_y = '0;
    seg_ch.end_x = '0;
    seg_ch.end_y = '0;
    clip_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: random stall bursts until the final part of the run.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (!sink_idle_off && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 12);
        clip_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      clip_ch.ready <= 1'b1;
    end
  end

  task automatic write_window(input lbc_reg_t idx, input logic signed [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_WIDTH'(idx) << 2;
    pwdata <= {{16{value[15]}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_window(input logic signed [15:0] l, input logic signed [15:0] b,
                            input logic signed [15:0] r, input logic signed [15:0] t);
    write_window(REG_LEFT, l);
    write_window(REG_BOTTOM, b);
    write_window(REG_RIGHT, r);
    write_window(REG_TOP, t);
  endtask

  task automatic drain_pipeline();
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Drives one segment; valid stays high across back-to-back transfers.
  task automatic send_segment(input logic signed [15:0] sx, input logic signed [15:0] sy,
                              input logic signed [15:0] ex, input logic signed [15:0] ey,
                              input bit allow_gap);
    int n;
    if (allow_gap && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 12);
      seg_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    seg_ch.valid <= 1'b1;
    seg_ch.start_x <= sx;
    seg_ch.start_y <= sy;
    seg_ch.end_x <= ex;
    seg_ch.end_y <= ey;
    do @(posedge clk); while (!seg_ch.ready);
    segment_count++;
  endtask

  task automatic end_burst();
    seg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] near(input logic signed [15:0] c);
    int v;
    v = int'(c) + $signed($urandom_range(0, 80)) - 40;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic random_phase(input int count, input bit gaps,
                              input logic signed [15:0] l, input logic signed [15:0] b,
                              input logic signed [15:0] r, input logic signed [15:0] t);
    logic signed [15:0] c[4];
    for (int i = 0; i < count; i++) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(0, 3))
          0: c[k] = 16'($urandom);
          1: c[k] = (k % 2 == 0) ? near(l) : near(b);
          2: c[k] = (k % 2 == 0) ? near(r) : near(t);
          default: c[k] = (k % 2 == 0) ? 16'($urandom_range(0, 65535))
                                       : 16'(int'(b) + int'($urandom_range(0, 600)));
        endcase
      end
      // Now and then make the segment axis-parallel or a single point.
      case ($urandom_range(0, 9))
        0: c[2] = c[0];
        1: c[3] = c[1];
        2: begin c[2] = c[0]; c[3] = c[1]; end
        default: ;
      endcase
      send_segment(c[0], c[1], c[2], c[3], gaps);
    end
    end_burst();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default window: inside, crossing, outside, parallel, points, extremes.
    send_segment(10, 10, 100, 200, 1'b0);
    send_segment(-100, 240, 800, 240, 1'b0);
    send_segment(320, -50, 320, 600, 1'b0);
    send_segment(-32768, -32768, 32767, 32767, 1'b0);
    send_segment(32767, -32768, -32768, 32767, 1'b0);
    send_segment(-10, 5, -10, 400, 1'b0);
    send_segment(700, 5, 700, 400, 1'b0);
    send_segment(5, -1, 600, -1, 1'b0);
    send_segment(5, 480, 600, 480, 1'b0);
    send_segment(0, 0, 0, 0, 1'b0);
    send_segment(639, 479, 639, 479, 1'b0);
    send_segment(640, 100, 640, 100, 1'b0);
    send_segment(-5, 600, 700, 500, 1'b0);
    send_segment(-200, 100, 100, -200, 1'b0);
    send_segment(0, 479, 639, 0, 1'b0);
    send_segment(1, 1, 2, 3, 1'b0);
    send_segment(-32768, 0, -32768, 0, 1'b0);
    end_burst();
    drain_pipeline();

    random_phase(120, 1'b1, 0, 0, 639, 479);
    drain_pipeline();

    set_window(-32768, -32768, 32767, 32767);
    send_segment(-32768, -32768, 32767, 32767, 1'b0);
    send_segment(32767, 32767, -32768, -32768, 1'b0);
    send_segment(-32768, 32767, -32768, -32768, 1'b0);
    end_burst();
    random_phase(120, 1'b1, -32768, -32768, 32767, 32767);
    drain_pipeline();

    set_window(100, 100, 50, 50);
    random_phase(40, 1'b1, 100, 100, 50, 50);
    drain_pipeline();

    set_window(-7, -3, -7, -3);
    random_phase(60, 1'b1, -7, -3, -7, -3);
    drain_pipeline();

    set_window(-1000, -500, 1000, 500);
    random_phase(140, 1'b1, -1000, -500, 1000, 500);
    drain_pipeline();

    // Final stretch with no idling on either side.
    sink_idle_off = 1'b1;
    random_phase(120, 1'b0, -1000, -500, 1000, 500);
    drain_pipeline();

    $display("%0d segments sent over five windows including extremes, degenerate and inverted",
             segment_count);
    $display("%0d results accepted, %0d rejected, %0d mismatches",
             accept_count, reject_count, mismatch_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
